[rtl/bbc_pkg.sv]
// ----------------------------------------------------------------------------
// bbc_pkg
// Shared constants, types and decode functions for the bracket balance
// checker: stack sizing, status codes, bracket kinds and characters.
// ----------------------------------------------------------------------------
package bbc_pkg;

  // Stack sizing
  localparam int STACK_DEPTH = 64;
  localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);

  // Status codes of a result beat
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NO_OPEN  = 3'd1;
  localparam logic [2:0] ST_MISMATCH = 3'd2;
  localparam logic [2:0] ST_NO_CLOSE = 3'd3;
  localparam logic [2:0] ST_OVERFLOW = 3'd4;

  // Bracket kinds as kept on the stack
  localparam logic [1:0] KIND_ROUND  = 2'd0;
  localparam logic [1:0] KIND_SQUARE = 2'd1;
  localparam logic [1:0] KIND_CURLY  = 2'd2;
  localparam logic [1:0] KIND_NONE   = 2'd3;

  // Bracket characters
  localparam logic [7:0] CH_OPEN_ROUND   = 8'h28; // (
  localparam logic [7:0] CH_OPEN_SQUARE  = 8'h5B; // [
  localparam logic [7:0] CH_OPEN_CURLY   = 8'h7B; // {
  localparam logic [7:0] CH_CLOSE_ROUND  = 8'h29; // )
  localparam logic [7:0] CH_CLOSE_SQUARE = 8'h5D; // ]
  localparam logic [7:0] CH_CLOSE_CURLY  = 8'h7D; // }

  typedef logic [1:0] kind_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] ch;
  } result_t;

  // Decode an opening bracket to its kind
  function automatic kind_t open_kind(input logic [7:0] c);
    kind_t k;
    unique case (c)
      CH_OPEN_ROUND:  k = KIND_ROUND;
      CH_OPEN_SQUARE: k = KIND_SQUARE;
      CH_OPEN_CURLY:  k = KIND_CURLY;
      default:        k = KIND_NONE;
    endcase
    return k;
  endfunction

  // Decode a closing bracket to its kind
  function automatic kind_t close_kind(input logic [7:0] c);
    kind_t k;
    unique case (c)
      CH_CLOSE_ROUND:  k = KIND_ROUND;
      CH_CLOSE_SQUARE: k = KIND_SQUARE;
      CH_CLOSE_CURLY:  k = KIND_CURLY;
      default:         k = KIND_NONE;
    endcase
    return k;
  endfunction

  // Map a stacked kind back to its opening character
  function automatic logic [7:0] open_char(input kind_t k);
    logic [7:0] c;
    unique case (k)
      KIND_ROUND:  c = CH_OPEN_ROUND;
      KIND_SQUARE: c = CH_OPEN_SQUARE;
      KIND_CURLY:  c = CH_OPEN_CURLY;
      default:     c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

[rtl/bracket_balance_checker.sv]
// ----------------------------------------------------------------------------
// bracket_balance_checker
// Streaming bracket matcher: one text byte per beat, one result beat per
// error or per clean end of text.
// ----------------------------------------------------------------------------
// Takes one text byte per clock cycle while in_stall is low, back to back,
// with no gap between texts. The bracket stack (STACK_DEPTH entries of 2
// bits) sits in a memory with two synchronous read ports; every cycle both
// ports prefetch the top and the entry below it for the stack depth of the
// next cycle, and a write to the top entry is forwarded, so each push or pop
// completes in the cycle its byte is accepted. Results go into a two-beat
// output buffer (output register plus skid register); in_stall rises only
// while both are full. The stack memory needs no clearing after reset.
// ----------------------------------------------------------------------------
module bracket_balance_checker
  import bbc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_text_byte,
  input  logic       in_end_of_text,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_status,
  output logic [7:0] out_offending_char
);

  // Stack memory and prefetched read data
  kind_t               stack_mem [STACK_DEPTH];
  kind_t               rd_top_r;
  kind_t               rd_sec_r;
  kind_t               fwd_kind_r;
  logic                fwd_r;

  // Control state
  logic [DEPTH_W-1:0]  depth_r;
  logic [DEPTH_W-1:0]  depth_nxt;
  logic                err_r;
  logic                err_nxt;

  // Output buffer
  logic                out_valid_r;
  result_t             out_r;
  logic                skid_valid_r;
  result_t             skid_r;

  // Per-beat decode
  logic                acc;
  kind_t               okind;
  kind_t               ckind;
  kind_t               top_kind;
  kind_t               end_kind;
  logic                wr_en;
  logic [ADDR_W-1:0]   wr_addr;
  logic [DEPTH_W-1:0]  rd_ptr1;
  logic [DEPTH_W-1:0]  rd_ptr2;
  logic [ADDR_W-1:0]   rd_addr1;
  logic [ADDR_W-1:0]   rd_addr2;
  logic [DEPTH_W-1:0]  depth_op;
  logic                err_hit;
  logic                res_v;
  result_t             res;

  assign acc      = in_valid && !in_stall;
  assign okind    = open_kind(in_text_byte);
  assign ckind    = close_kind(in_text_byte);
  assign top_kind = fwd_r ? fwd_kind_r : rd_top_r;
  assign wr_addr  = depth_r[ADDR_W-1:0];

  // Push, pop, check and end-of-text report
  always_comb begin
    depth_op = depth_r;
    err_hit  = 1'b0;
    wr_en    = 1'b0;
    res_v    = 1'b0;
    res      = '{status: ST_OK, ch: 8'h00};
    end_kind = top_kind;
    if (acc && !err_r) begin
      if (okind != KIND_NONE) begin
        if (depth_r == DEPTH_W'(STACK_DEPTH)) begin
          err_hit = 1'b1;
          res     = '{status: ST_OVERFLOW, ch: in_text_byte};
        end else begin
          wr_en    = 1'b1;
          depth_op = depth_r + DEPTH_W'(1);
          end_kind = okind;
        end
      end else if (ckind != KIND_NONE) begin
        if (depth_r == '0) begin
          err_hit = 1'b1;
          res     = '{status: ST_NO_OPEN, ch: in_text_byte};
        end else begin
          depth_op = depth_r - DEPTH_W'(1);
          end_kind = rd_sec_r;
          if (top_kind != ckind) begin
            err_hit = 1'b1;
            res     = '{status: ST_MISMATCH, ch: in_text_byte};
          end
        end
      end
      if (err_hit) begin
        res_v = 1'b1;
      end else if (in_end_of_text) begin
        res_v = 1'b1;
        if (depth_op != '0) begin
          res = '{status: ST_NO_CLOSE, ch: open_char(end_kind)};
        end else begin
          res = '{status: ST_OK, ch: 8'h00};
        end
      end
    end
  end

  // Next depth and error flag; end of text clears both
  always_comb begin
    depth_nxt = depth_op;
    err_nxt   = err_r || err_hit;
    if (acc && in_end_of_text) begin
      depth_nxt = '0;
      err_nxt   = 1'b0;
    end
  end

  // Prefetch addresses for the top and the entry below it
  assign rd_ptr1  = depth_nxt - DEPTH_W'(1);
  assign rd_ptr2  = depth_nxt - DEPTH_W'(2);
  assign rd_addr1 = rd_ptr1[ADDR_W-1:0];
  assign rd_addr2 = rd_ptr2[ADDR_W-1:0];

  // Stack memory: one write, two registered reads
  always_ff @(posedge clk) begin
    if (wr_en) begin
      stack_mem[wr_addr] <= okind;
    end
    rd_top_r   <= stack_mem[rd_addr1];
    rd_sec_r   <= stack_mem[rd_addr2];
    fwd_kind_r <= okind;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= '0;
      err_r   <= 1'b0;
      fwd_r   <= 1'b0;
    end else begin
      depth_r <= depth_nxt;
      err_r   <= err_nxt;
      fwd_r   <= wr_en && (wr_addr == rd_addr1);
    end
  end

  // Output register and skid: drain skid first, else load new result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || !out_stall) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r  <= res_v;
      end
    end else if (res_v) begin
      skid_valid_r <= 1'b1;
    end
  end

  // Payload of the output buffer
  always_ff @(posedge clk) begin
    if (!out_valid_r || !out_stall) begin
      if (skid_valid_r) begin
        out_r <= skid_r;
      end else if (res_v) begin
        out_r <= res;
      end
    end else if (res_v) begin
      skid_r <= res;
    end
  end

  assign in_stall           = skid_valid_r;
  assign out_valid          = out_valid_r;
  assign out_status         = out_r.status;
  assign out_offending_char = out_r.ch;

  // Stack never grows past its depth
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= DEPTH_W'(STACK_DEPTH))
    else $error("stack depth beyond capacity");

  // Skid holds a beat only behind a full output register
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid full while output register empty");

  // End of text leaves an empty stack and a clear error flag
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_end_of_text) |=> (depth_r == '0 && !err_r))
    else $error("end of text did not clear the stack");

  // No-error beat carries a zero character
  a_ok_zero_char: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_OK) |-> out_offending_char == 8'h00)
    else $error("no-error result with nonzero character");

endmodule

[tb/sv/bbc_result_checker.sv]
// ----------------------------------------------------------------------------
// bbc_result_checker
// Watches both channels of the bracket balance checker. It keeps its own
// copy of the bracket stack, predicts the result beat, if any, of every
// accepted text byte, and compares each result beat with the oldest prediction.
// ----------------------------------------------------------------------------
module bbc_result_checker
  import bbc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_text_byte,
  input  logic       in_end_of_text,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [2:0] out_status,
  input  logic [7:0] out_offending_char,
  output int         fail_count,
  output int         pending,
  output int         clean_count,
  output int         unclosed_count,
  output int         bracket_err_count,
  output int         overflow_count
);

  localparam int MAX_REPORTS = 100;

  // Model state: stack of bracket kinds, its depth, and the per-text error flag
  kind_t   kind_stack [STACK_DEPTH];
  int      nest_depth;
  bit      text_failed;
  result_t expected_results [$];
  int      mismatches;
  int      n_clean;
  int      n_unclosed;
  int      n_bracket_err;
  int      n_overflow;

  initial begin
    fail_count        = 0;
    pending           = 0;
    clean_count       = 0;
    unclosed_count    = 0;
    bracket_err_count = 0;
    overflow_count    = 0;
    mismatches        = 0;
    n_clean           = 0;
    n_unclosed        = 0;
    n_bracket_err     = 0;
    n_overflow        = 0;
    nest_depth        = 0;
    text_failed       = 1'b0;
  end

  task automatic expect_result(input logic [2:0] st, input logic [7:0] ch);
    result_t r;
    r.status = st;
    r.ch     = ch;
    expected_results.push_back(r);
  endtask

  // Advance the stack model by one text byte and queue any result it causes
  task automatic predict_beat(input logic [7:0] b, input logic last);
    bit         is_open;
    bit         is_close;
    kind_t      k;
    logic [7:0] top_char;
    is_open  = 1'b0;
    is_close = 1'b0;
    k        = KIND_NONE;
    case (b)
      CH_OPEN_ROUND: begin
        is_open = 1'b1;
        k       = KIND_ROUND;
      end
      CH_OPEN_SQUARE: begin
        is_open = 1'b1;
        k       = KIND_SQUARE;
      end
      CH_OPEN_CURLY: begin
        is_open = 1'b1;
        k       = KIND_CURLY;
      end
      CH_CLOSE_ROUND: begin
        is_close = 1'b1;
        k        = KIND_ROUND;
      end
      CH_CLOSE_SQUARE: begin
        is_close = 1'b1;
        k        = KIND_SQUARE;
      end
      CH_CLOSE_CURLY: begin
        is_close = 1'b1;
        k        = KIND_CURLY;
      end
      default: ;
    endcase

    if (!text_failed) begin
      if (is_open) begin
        // A full stack refuses the push and fails the text
        if (nest_depth >= STACK_DEPTH) begin
          expect_result(ST_OVERFLOW, b);
          text_failed = 1'b1;
        end else begin
          kind_stack[nest_depth] = k;
          nest_depth++;
        end
      end else if (is_close) begin
        if (nest_depth == 0) begin
          expect_result(ST_NO_OPEN, b);
          text_failed = 1'b1;
        end else begin
          // Pop first, then compare kinds
          nest_depth--;
          if (kind_stack[nest_depth] != k) begin
            expect_result(ST_MISMATCH, b);
            text_failed = 1'b1;
          end
        end
      end

      // Clean end of text: report the unclosed top bracket or a clean text
      if (last && !text_failed) begin
        if (nest_depth > 0) begin
          case (kind_stack[nest_depth - 1])
            KIND_ROUND:  top_char = CH_OPEN_ROUND;
            KIND_SQUARE: top_char = CH_OPEN_SQUARE;
            KIND_CURLY:  top_char = CH_OPEN_CURLY;
            default:     top_char = 8'h00;
          endcase
          expect_result(ST_NO_CLOSE, top_char);
        end else begin
          expect_result(ST_OK, 8'h00);
        end
      end
    end

    if (last) begin
      nest_depth  = 0;
      text_failed = 1'b0;
    end
  endtask

  // Compare one result beat against the oldest prediction
  task automatic check_result(input logic [2:0] st, input logic [7:0] ch);
    result_t want;
    if (expected_results.size() == 0) begin
      if (mismatches < MAX_REPORTS)
        $error("unexpected result beat: status %0d, offending_char 0x%02h", st, ch);
      mismatches++;
    end else begin
      want = expected_results.pop_front();
      if (st !== want.status) begin
        if (mismatches < MAX_REPORTS)
          $error("status: expected %0d, actual %0d", want.status, st);
        mismatches++;
      end
      if (ch !== want.ch) begin
        if (mismatches < MAX_REPORTS)
          $error("offending_char: expected 0x%02h, actual 0x%02h", want.ch, ch);
        mismatches++;
      end
      case (want.status)
        ST_OK:       n_clean++;
        ST_NO_CLOSE: n_unclosed++;
        ST_OVERFLOW: n_overflow++;
        default:     n_bracket_err++;
      endcase
    end
  endtask

  // Input beats are predicted before result beats of the same edge are checked
  always @(posedge clk) begin
    if (!rst_n) begin
      nest_depth  = 0;
      text_failed = 1'b0;
      expected_results.delete();
    end else begin
      if (in_valid && !in_stall)
        predict_beat(in_text_byte, in_end_of_text);
      if (out_valid && !out_stall)
        check_result(out_status, out_offending_char);
    end
    fail_count        <= mismatches;
    pending           <= expected_results.size();
    clean_count       <= n_clean;
    unclosed_count    <= n_unclosed;
    bracket_err_count <= n_bracket_err;
    overflow_count    <= n_overflow;
  end

endmodule

[tb/sv/tb_bracket_balance_checker.sv]
// ----------------------------------------------------------------------------
// tb_bracket_balance_checker
// Drives texts into the bracket balance checker: a short directed set, a
// forced full-stack overflow, then random nested, deep and noise texts, with
// random gaps on the input and random back-pressure on the result channel.
// ----------------------------------------------------------------------------
module tb_bracket_balance_checker;
  import bbc_pkg::*;

  localparam int ITEM_GOAL    = 1350;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 20;

  logic       clk            = 1'b0;
  logic       rst_n          = 1'b0;
  logic       in_valid       = 1'b0;
  logic       in_stall;
  logic [7:0] in_text_byte   = 8'h00;
  logic       in_end_of_text = 1'b0;
  logic       out_valid;
  logic       out_stall      = 1'b0;
  logic [2:0] out_status;
  logic [7:0] out_offending_char;

  int fail_count;
  int pending;
  int clean_count;
  int unclosed_count;
  int bracket_err_count;
  int overflow_count;

  int         cycle_count   = 0;
  int         bytes_sent    = 0;
  int         texts_sent    = 0;
  bit         steady        = 1'b0;
  int         steady_timer  = 0;
  int         stall_left    = 0;
  logic [7:0] text_bytes [$];
  kind_t      open_kinds [$];

  bracket_balance_checker DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_text_byte       (in_text_byte),
    .in_end_of_text     (in_end_of_text),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_offending_char (out_offending_char)
  );

  bbc_result_checker result_mon (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_text_byte       (in_text_byte),
    .in_end_of_text     (in_end_of_text),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_offending_char (out_offending_char),
    .fail_count         (fail_count),
    .pending            (pending),
    .clean_count        (clean_count),
    .unclosed_count     (unclosed_count),
    .bracket_err_count  (bracket_err_count),
    .overflow_count     (overflow_count)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Cycle limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still expected", cycle_count, pending);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Alternate between stretches with idling and stretches without
  always @(posedge clk) begin
    if (steady_timer == 0) begin
      steady       <= ($urandom_range(0, 3) == 0);
      steady_timer <= $urandom_range(100, 400);
    end else begin
      steady_timer <= steady_timer - 1;
    end
  end

  // Result back-pressure: mostly short stalls, a few long ones
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (steady) begin
      out_stall <= 1'b0;
    end else begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6: begin
          out_stall  <= 1'b1;
          stall_left <= $urandom_range(0, 2);
        end
        7: begin
          out_stall  <= 1'b1;
          stall_left <= $urandom_range(8, 40);
        end
        default: out_stall <= 1'b0;
      endcase
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 60)
      return 0;
    else if (r < 93)
      return $urandom_range(1, 3);
    else
      return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] open_of(input kind_t k);
    case (k)
      KIND_ROUND:  return CH_OPEN_ROUND;
      KIND_SQUARE: return CH_OPEN_SQUARE;
      default:     return CH_OPEN_CURLY;
    endcase
  endfunction

  function automatic logic [7:0] close_of(input kind_t k);
    case (k)
      KIND_ROUND:  return CH_CLOSE_ROUND;
      KIND_SQUARE: return CH_CLOSE_SQUARE;
      default:     return CH_CLOSE_CURLY;
    endcase
  endfunction

  function automatic logic [7:0] any_bracket();
    if ($urandom_range(0, 1) == 0)
      return open_of(kind_t'($urandom_range(0, 2)));
    else
      return close_of(kind_t'($urandom_range(0, 2)));
  endfunction

  // Send the queued text, one beat per byte, end flag on the last byte
  task automatic send_text();
    int gap;
    for (int i = 0; i < text_bytes.size(); i++) begin
      gap = pick_gap();
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_valid       <= 1'b1;
      in_text_byte   <= text_bytes[i];
      in_end_of_text <= (i == text_bytes.size() - 1);
      @(posedge clk);
      while (in_stall) @(posedge clk);
    end
    bytes_sent += text_bytes.size();
    texts_sent++;
  endtask

  // Mostly well-nested brackets with filler; sometimes left open or corrupted
  task automatic build_nested_text();
    int target;
    int r;
    text_bytes.delete();
    open_kinds.delete();
    target = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 16);
    for (int i = 0; i < target; i++) begin
      r = $urandom_range(0, 9);
      if (r < 3) begin
        text_bytes.push_back(8'($urandom_range(0, 255)));
      end else if (r < 6 || open_kinds.size() == 0) begin
        if (open_kinds.size() < STACK_DEPTH) begin
          open_kinds.push_back(kind_t'($urandom_range(0, 2)));
          text_bytes.push_back(open_of(open_kinds[$]));
        end
      end else begin
        text_bytes.push_back(close_of(open_kinds.pop_back()));
      end
    end
    if ($urandom_range(0, 4) != 0) begin
      while (open_kinds.size() > 0)
        text_bytes.push_back(close_of(open_kinds.pop_back()));
    end
    if (text_bytes.size() > 0 && $urandom_range(0, 5) == 0)
      text_bytes[$urandom_range(0, text_bytes.size() - 1)] = any_bracket();
    if (text_bytes.size() == 0)
      text_bytes.push_back(8'($urandom_range(0, 255)));
  endtask

  // Random bytes, half of them brackets
  task automatic build_noise_text();
    int len;
    text_bytes.delete();
    len = $urandom_range(1, 12);
    repeat (len) begin
      if ($urandom_range(0, 1) == 0)
        text_bytes.push_back(any_bracket());
      else
        text_bytes.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  // Fill the stack to or near its depth; push past it, unwind, or leave open
  task automatic build_deep_text(input bit overflow);
    int opens;
    text_bytes.delete();
    open_kinds.delete();
    opens = overflow ? STACK_DEPTH : STACK_DEPTH - $urandom_range(0, 1);
    repeat (opens) begin
      open_kinds.push_back(kind_t'($urandom_range(0, 2)));
      text_bytes.push_back(open_of(open_kinds[$]));
    end
    if (overflow) begin
      text_bytes.push_back(open_of(kind_t'($urandom_range(0, 2))));
      repeat ($urandom_range(0, 3)) text_bytes.push_back(any_bracket());
    end else if ($urandom_range(0, 2) != 0) begin
      while (open_kinds.size() > 0)
        text_bytes.push_back(close_of(open_kinds.pop_back()));
    end
  endtask

  initial begin
    int  r;
    bit  first_deep;
    first_deep = 1'b1;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed texts: clean, all-bit bytes, no-open, mismatch and unclosed errors, tail after error
    text_bytes = '{CH_OPEN_ROUND, CH_CLOSE_ROUND};
    send_text();
    text_bytes = '{CH_OPEN_SQUARE, CH_OPEN_CURLY, CH_OPEN_ROUND,
                   CH_CLOSE_ROUND, CH_CLOSE_CURLY, CH_CLOSE_SQUARE};
    send_text();
    text_bytes = '{8'h00};
    send_text();
    text_bytes = '{CH_CLOSE_ROUND, CH_OPEN_ROUND, CH_CLOSE_ROUND};
    send_text();
    text_bytes = '{CH_OPEN_ROUND, CH_CLOSE_SQUARE};
    send_text();
    text_bytes = '{CH_OPEN_SQUARE, CH_CLOSE_CURLY, 8'hFF};
    send_text();
    text_bytes = '{CH_OPEN_CURLY, CH_CLOSE_ROUND};
    send_text();
    text_bytes = '{CH_OPEN_ROUND, CH_OPEN_SQUARE, CH_OPEN_CURLY, 8'hFF};
    send_text();
    text_bytes = '{CH_CLOSE_CURLY};
    send_text();

    // Random texts; the first one always pushes past a full stack
    while (bytes_sent < ITEM_GOAL) begin
      r = $urandom_range(0, 99);
      if (first_deep || r < 4) begin
        build_deep_text(first_deep || ($urandom_range(0, 1) == 1));
        first_deep = 1'b0;
      end else if (r < 20) begin
        build_noise_text();
      end else begin
        build_nested_text();
      end
      send_text();
    end
    in_valid <= 1'b0;

    // Drain outstanding results, then give late beats a chance to show up
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d texts, %0d bytes, with input gaps and result back-pressure.",
             texts_sent, bytes_sent);
    $display("Results: %0d clean, %0d unclosed, %0d bracket errors, %0d overflows.",
             clean_count, unclosed_count, bracket_err_count, overflow_count);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/bbc_pkg.sv
rtl/bracket_balance_checker.sv
tb/sv/bbc_result_checker.sv
tb/sv/tb_bracket_balance_checker.sv
